// ----- rtl/core/mqtt_publish_packet_parser_core_assert.svh -----
// assertion helpers for the publish packet parser
`ifndef MQTT_PUBLISH_PACKET_PARSER_CORE_ASSERT_SVH
`define MQTT_PUBLISH_PACKET_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MQTTPP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mqttpp: same-cycle check failed");
`define MQTTPP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mqttpp: next-cycle check failed");
`else
`define MQTTPP_ASSERT_IMP(label, clk, rst, ante, cons)
`define MQTTPP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/mqttpp_pkg.sv -----
`default_nettype none

package mqttpp_pkg;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_TOPIC   = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_TOPIC_CAPACITY   = 1'b0,
    REG_PAYLOAD_CAPACITY = 1'b1
  } reg_index_t;

  localparam logic [7:0]  TYPE_MASK       = 8'hF0;
  localparam logic [7:0]  TYPE_PUBLISH    = 8'h30;
  localparam logic [7:0]  QOS_MASK        = 8'h06;
  localparam logic [7:0]  LEN_DIGIT_MASK  = 8'd127;
  localparam logic [7:0]  LEN_CONTINUE    = 8'd128;
  localparam logic [15:0] TOPIC_CAP_RESET = 16'd64;
  localparam logic [15:0] PAYLOAD_CAP_RESET = 16'd256;
  localparam logic [15:0] INDEX_MAX       = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/core/mqtt_publish_packet_parser_core.sv -----
`default_nettype none
`include "mqtt_publish_packet_parser_core_assert.svh"

// Streaming parser for received MQTT 3.1.1 PUBLISH packets. Feed the packet one byte per
// transaction with last_byte on the final byte of the buffer; every input transaction gives
// exactly one result transaction, offered in the cycle after acceptance, through a registered output
// stage. A new byte is taken every cycle while the output is free or being taken, so the
// sustained rate is one byte per clock, set by the single per-byte state update. Each result
// carries the byte tagged as topic or payload (or nothing), and the result for the last byte
// carries packet_done with status (0 ok, 1 malformed). Bytes delivered before an error is
// found are not withdrawn: discard them when status is 1. The user must write the topic and
// payload capacities through the cfg port only while the parser is idle; the block does not
// enforce it. Each kind delivers at most capacity-1 bytes; a zero capacity reports malformed.
module mqtt_publish_packet_parser_core (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [7:0]                data_byte,
  input  wire                       last_byte,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [7:0]                out_byte,
  output mqttpp_pkg::kind_t         byte_kind,
  output logic                      packet_done,
  output logic                      status,
  input  wire                       cfg_write,
  input  wire  mqttpp_pkg::reg_index_t cfg_index,
  input  wire  [15:0]               cfg_data
);
  import mqttpp_pkg::*;

  typedef enum logic [3:0] {
    PH_FIXED,
    PH_LEN,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PID_HI,
    PH_PID_LO,
    PH_PAYLOAD,
    PH_TAIL,
    PH_ERR
  } phase_t;

  logic [15:0] topic_capacity;
  logic [15:0] payload_capacity;

  phase_t      phase, phase_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] packet_end, packet_end_next;
  logic [20:0] length_value, length_value_next;
  logic [1:0]  length_digits, length_digits_next;
  logic [15:0] topic_length, topic_length_next;
  logic [15:0] topic_taken, topic_taken_next;
  logic [15:0] payload_taken, payload_taken_next;
  logic        has_packet_id, has_packet_id_next;

  logic        in_accept;
  logic [7:0]  res_byte;
  kind_t       res_kind;
  logic        res_status;

  logic [16:0] idx_inc;
  logic [6:0]  digit;
  logic [21:0] end_sum;
  logic [17:0] topic_end;
  logic        bad;

  // phase after the last topic byte; next_idx is the index of the following byte
  function automatic phase_t after_topic(input logic pid, input logic [16:0] next_idx,
                                         input logic [15:0] pend);
    phase_t ph;
    if (pid) begin
      if (({1'b0, next_idx} + 18'd2) > {2'b00, pend}) ph = PH_ERR;
      else ph = PH_PID_HI;
    end else begin
      ph = (next_idx < {1'b0, pend}) ? PH_PAYLOAD : PH_TAIL;
    end
    return ph;
  endfunction

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign idx_inc   = {1'b0, bytes_seen} + 17'd1;
  assign digit     = data_byte[6:0] & LEN_DIGIT_MASK[6:0];
  assign topic_end = {1'b0, idx_inc} + {2'b00, topic_length[15:8], data_byte};

  always_comb begin
    phase_next         = phase;
    bytes_seen_next    = (bytes_seen < INDEX_MAX) ? bytes_seen + 16'd1 : bytes_seen;
    packet_end_next    = packet_end;
    length_value_next  = length_value;
    length_digits_next = length_digits;
    topic_length_next  = topic_length;
    topic_taken_next   = topic_taken;
    payload_taken_next = payload_taken;
    has_packet_id_next = has_packet_id;
    res_byte           = 8'd0;
    res_kind           = KIND_NONE;
    res_status         = 1'b0;
    end_sum            = 22'd0;
    bad                = 1'b0;

    case (phase)
      PH_FIXED: begin
        if ((data_byte & TYPE_MASK) != TYPE_PUBLISH) begin
          phase_next = PH_ERR;
        end else begin
          has_packet_id_next = (data_byte & QOS_MASK) != 8'd0;
          phase_next         = PH_LEN;
        end
      end
      PH_LEN: begin
        if (length_digits == 2'd3) begin
          phase_next = PH_ERR;
        end else begin
          case (length_digits)
            2'd0:    length_value_next = {14'd0, digit};
            2'd1:    length_value_next = length_value | {7'd0, digit, 7'd0};
            2'd2:    length_value_next = length_value | {digit, 14'd0};
            default: length_value_next = length_value;
          endcase
          length_digits_next = length_digits + 2'd1;
          end_sum = {5'd0, idx_inc} + {1'b0, length_value_next};
          if ((data_byte & LEN_CONTINUE) == 8'd0) begin
            if (end_sum > 22'd65535 || length_value_next < 21'd2) begin
              phase_next = PH_ERR;
            end else begin
              packet_end_next = end_sum[15:0];
              phase_next      = PH_TLEN_HI;
            end
          end
        end
      end
      PH_TLEN_HI: begin
        topic_length_next = {data_byte, 8'd0};
        phase_next        = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        topic_length_next = {topic_length[15:8], data_byte};
        if (topic_end > {2'b00, packet_end}) begin
          phase_next = PH_ERR;
        end else if (topic_length_next != 16'd0) begin
          phase_next = PH_TOPIC;
        end else begin
          phase_next = after_topic(has_packet_id, idx_inc, packet_end);
        end
      end
      PH_TOPIC: begin
        if (topic_capacity != 16'd0 && topic_taken < topic_capacity - 16'd1) begin
          res_byte = data_byte;
          res_kind = KIND_TOPIC;
        end
        topic_taken_next = topic_taken + 16'd1;
        if (topic_taken_next >= topic_length)
          phase_next = after_topic(has_packet_id, idx_inc, packet_end);
      end
      PH_PID_HI: phase_next = PH_PID_LO;
      PH_PID_LO: phase_next = (idx_inc < {1'b0, packet_end}) ? PH_PAYLOAD : PH_TAIL;
      PH_PAYLOAD: begin
        if (payload_capacity != 16'd0 && payload_taken < payload_capacity - 16'd1) begin
          res_byte = data_byte;
          res_kind = KIND_PAYLOAD;
        end
        payload_taken_next = payload_taken + 16'd1;
        if (idx_inc >= {1'b0, packet_end}) phase_next = PH_TAIL;
      end
      default: ;
    endcase

    if (last_byte) begin
      bad = (phase_next == PH_ERR) || topic_capacity == 16'd0 || payload_capacity == 16'd0;
      if (phase_next == PH_LEN || phase_next == PH_TLEN_HI || phase_next == PH_TLEN_LO)
        bad = 1'b1;
      else if (phase_next != PH_ERR && {1'b0, packet_end_next} > idx_inc)
        bad = 1'b1;
      res_status         = bad;
      phase_next         = PH_FIXED;
      bytes_seen_next    = 16'd0;
      packet_end_next    = 16'd0;
      length_value_next  = 21'd0;
      length_digits_next = 2'd0;
      topic_length_next  = 16'd0;
      topic_taken_next   = 16'd0;
      payload_taken_next = 16'd0;
      has_packet_id_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_capacity   <= TOPIC_CAP_RESET;
      payload_capacity <= PAYLOAD_CAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOPIC_CAPACITY:   topic_capacity   <= cfg_data;
        REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIXED;
      bytes_seen    <= 16'd0;
      packet_end    <= 16'd0;
      length_value  <= 21'd0;
      length_digits <= 2'd0;
      topic_length  <= 16'd0;
      topic_taken   <= 16'd0;
      payload_taken <= 16'd0;
      has_packet_id <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        phase         <= phase_next;
        bytes_seen    <= bytes_seen_next;
        packet_end    <= packet_end_next;
        length_value  <= length_value_next;
        length_digits <= length_digits_next;
        topic_length  <= topic_length_next;
        topic_taken   <= topic_taken_next;
        payload_taken <= payload_taken_next;
        has_packet_id <= has_packet_id_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on every input transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte    <= res_byte;
      byte_kind   <= res_kind;
      packet_done <= last_byte;
      status      <= res_status;
    end
  end

  `MQTTPP_ASSERT_IMP(a_status_only_done, clk, rst, out_valid && status, packet_done)
  `MQTTPP_ASSERT_IMP(a_idle_byte_zero, clk, rst, out_valid && byte_kind == KIND_NONE, out_byte == 8'd0)
  `MQTTPP_ASSERT_IMP(a_topic_in_range, clk, rst, phase == PH_TOPIC, topic_taken < topic_length)
  `MQTTPP_ASSERT_NXT(a_last_clears, clk, rst, in_accept && last_byte, phase == PH_FIXED && bytes_seen == 16'd0)
  `MQTTPP_ASSERT_NXT(a_err_silent, clk, rst, in_accept && phase == PH_ERR, byte_kind == KIND_NONE)

endmodule

`default_nettype wire

// ----- dv/tb_mqtt_publish_packet_parser_core.sv -----
`default_nettype none

module tb_mqtt_publish_packet_parser_core;
  import mqttpp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [3:0] {
    ST_HEADER, ST_LEN, ST_TLEN_HI, ST_TLEN_LO, ST_TOPIC,
    ST_PID_HI, ST_PID_LO, ST_PAYLOAD, ST_TAIL, ST_ERR
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       done;
    logic       status;
  } parsed_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  kind_t      byte_kind;
  logic       packet_done;
  logic       status;
  logic       cfg_write;
  reg_index_t cfg_index;
  logic [15:0] cfg_data;

  mqtt_publish_packet_parser_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_kind   (byte_kind),
    .packet_done (packet_done),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // parser mirror state
  logic [15:0]  topic_cap;
  logic [15:0]  payload_cap;
  parse_state_t ph;
  logic [15:0]  seen;
  logic [16:0]  end_pos;
  logic [20:0]  len_val;
  logic [1:0]   len_digits;
  logic [15:0]  tlen;
  logic [15:0]  ttaken;
  logic [15:0]  ptaken;
  logic         has_pid;
  logic         err_seen;

  parsed_t     parsed_q[$];
  int unsigned mismatches;
  int unsigned quiet;
  int unsigned src_idle;
  int unsigned sink_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse();
    ph = ST_HEADER;
    seen = '0;
    end_pos = '0;
    len_val = '0;
    len_digits = '0;
    tlen = '0;
    ttaken = '0;
    ptaken = '0;
    has_pid = 1'b0;
    err_seen = 1'b0;
  endfunction

  function automatic void mark_bad();
    err_seen = 1'b1;
    ph = ST_ERR;
  endfunction

  // nxt is the position of the byte after the topic
  function automatic void after_topic(int unsigned nxt);
    if (has_pid) begin
      if (nxt + 2 > end_pos) mark_bad();
      else ph = ST_PID_HI;
    end else begin
      ph = (nxt < end_pos) ? ST_PAYLOAD : ST_TAIL;
    end
  endfunction

  function automatic parsed_t parse_byte(logic [7:0] b, logic last);
    parsed_t     r;
    int unsigned idx;
    int unsigned stop;
    logic        bad;
    r = '{8'h00, KIND_NONE, last, 1'b0};
    idx = seen;
    case (ph)
      ST_HEADER: begin
        if ((b & TYPE_MASK) != TYPE_PUBLISH) begin
          mark_bad();
        end else begin
          has_pid = (b & QOS_MASK) != 0;
          ph = ST_LEN;
        end
      end
      ST_LEN: begin
        if (len_digits == 2'd3) begin
          mark_bad();
        end else begin
          len_val = len_val + (21'(b & LEN_DIGIT_MASK) << (7 * len_digits));
          len_digits = len_digits + 2'd1;
          if ((b & LEN_CONTINUE) == 0) begin
            stop = idx + 1 + len_val;
            if (stop > INDEX_MAX || len_val < 2) begin
              mark_bad();
            end else begin
              end_pos = stop[16:0];
              ph = ST_TLEN_HI;
            end
          end
        end
      end
      ST_TLEN_HI: begin
        tlen = {b, 8'h00};
        ph = ST_TLEN_LO;
      end
      ST_TLEN_LO: begin
        tlen[7:0] = b;
        if (idx + 1 + tlen > end_pos) mark_bad();
        else if (tlen != 0) ph = ST_TOPIC;
        else after_topic(idx + 1);
      end
      ST_TOPIC: begin
        if (topic_cap != 0 && ttaken < topic_cap - 16'd1) begin
          r.data = b;
          r.kind = KIND_TOPIC;
        end
        ttaken = ttaken + 16'd1;
        if (ttaken >= tlen) after_topic(idx + 1);
      end
      ST_PID_HI: ph = ST_PID_LO;
      ST_PID_LO: ph = (idx + 1 < end_pos) ? ST_PAYLOAD : ST_TAIL;
      ST_PAYLOAD: begin
        if (payload_cap != 0 && ptaken < payload_cap - 16'd1) begin
          r.data = b;
          r.kind = KIND_PAYLOAD;
        end
        ptaken = ptaken + 16'd1;
        if (idx + 1 >= end_pos) ph = ST_TAIL;
      end
      default: ;
    endcase
    if (seen != INDEX_MAX) seen = seen + 16'd1;
    if (last) begin
      bad = err_seen || topic_cap == 0 || payload_cap == 0;
      if (ph == ST_LEN || ph == ST_TLEN_HI || ph == ST_TLEN_LO) bad = 1'b1;
      else if (ph != ST_ERR && end_pos > idx + 1) bad = 1'b1;
      r.status = bad;
      clear_parse();
    end
    return r;
  endfunction

  // header, remaining length (padded to at least ndig digits), topic length field, body
  function automatic byte_q_t make_packet(logic [7:0] hdr, int unsigned rem,
                                          logic [15:0] tfield, int unsigned body,
                                          int unsigned ndig);
    byte_q_t     q;
    int unsigned nd;
    int unsigned d;
    q.push_back(hdr);
    nd = 1;
    while ((rem >> (7 * nd)) != 0) nd++;
    if (ndig > nd) nd = ndig;
    for (int i = 0; i < nd; i++) begin
      d = (rem >> (7 * i)) & LEN_DIGIT_MASK;
      if (i < nd - 1) d = d | LEN_CONTINUE;
      q.push_back(d[7:0]);
    end
    q.push_back(tfield[15:8]);
    q.push_back(tfield[7:0]);
    repeat (body) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // mostly short, now and then right around the capacity limit
  function automatic int unsigned pick_len(logic [15:0] cap, int unsigned typical);
    if (cap != 0 && cap <= 300 && $urandom_range(19) == 0)
      return $urandom_range(cap + 1, (cap > 2) ? cap - 2 : 0);
    return $urandom_range(typical);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parsed_q.push_back(parse_byte(b, l));
    @(negedge clk);
  endtask

  task automatic send_buffer(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // called at a falling edge; leaves the parser idle with nothing outstanding
  task automatic drain();
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_caps(input logic [15:0] tcap, input logic [15:0] pcap);
    cfg_write <= 1'b1;
    cfg_index <= REG_TOPIC_CAPACITY;
    cfg_data <= tcap;
    @(negedge clk);
    cfg_index <= REG_PAYLOAD_CAPACITY;
    cfg_data <= pcap;
    @(negedge clk);
    cfg_write <= 1'b0;
    topic_cap = tcap;
    payload_cap = pcap;
  endtask

  task automatic send_random_packet(output int unsigned n);
    byte_q_t     q;
    int unsigned pick;
    int unsigned qos;
    int unsigned tl;
    int unsigned pl;
    int unsigned rem;
    int unsigned body;
    int unsigned ndig;
    int unsigned cut;
    logic [7:0]  hdr;
    logic [15:0] tfield;
    pick = $urandom_range(99);
    qos = $urandom_range(3);
    hdr = {TYPE_PUBLISH[7:4], 1'($urandom_range(1)), qos[1:0], 1'($urandom_range(1))};
    tl = pick_len(topic_cap, 12);
    pl = pick_len(payload_cap, 24);
    rem = 2 + tl + pl + ((qos != 0) ? 2 : 0);
    body = rem - 2;
    tfield = 16'(tl);
    ndig = ($urandom_range(9) == 0) ? $urandom_range(3) : 0;
    if (pick < 62) begin
      // well-formed
    end else if (pick < 68) begin
      body = body + $urandom_range(1, 4);
    end else if (pick < 72) begin
      hdr[7:4] = 4'($urandom_range(15));
      if (hdr[7:4] == TYPE_PUBLISH[7:4]) hdr[7:4] = 4'hB;
    end else if (pick < 75) begin
      ndig = 4;
    end else if (pick < 78) begin
      rem = $urandom_range(1);
      body = $urandom_range(3);
    end else if (pick < 82) begin
      tfield = 16'(rem - 2 + $urandom_range(1, 3));
    end else if (pick < 86) begin
      // packet id runs past the end
      hdr[2:1] = 2'($urandom_range(1, 3));
      rem = 2 + tl + $urandom_range(1);
      body = rem - 2;
    end else if (pick < 89) begin
      rem = $urandom_range(65535, 2097151);
      body = $urandom_range(4);
    end
    q = make_packet(hdr, rem, tfield, body, ndig);
    if (pick >= 89 && pick < 95 && q.size() > 1) begin
      cut = $urandom_range(1, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
    end
    if (pick >= 95) begin
      q.delete();
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
    end
    send_buffer(q);
    n = q.size();
  endtask

  task automatic test_directed_packets();
    byte_q_t q;
    send_buffer(make_packet(TYPE_PUBLISH, 2, 16'd0, 0, 0));
    // qos 1, one topic byte, id, one payload byte, then two bytes past the end
    send_buffer(make_packet(8'h32, 6, 16'd1, 6, 0));
    send_buffer(make_packet(8'h3F, 9, 16'd2, 7, 0));
    send_buffer(make_packet(8'hC5, 2, 16'd0, 0, 0));
    send_buffer(make_packet(TYPE_PUBLISH, 1, 16'd0, 0, 4));
    send_buffer(make_packet(TYPE_PUBLISH, 65535, 16'd0, 1, 3));
    send_buffer(make_packet(TYPE_PUBLISH, 1, 16'd0, 0, 0));
    send_buffer(make_packet(TYPE_PUBLISH, 3, 16'd2, 1, 0));
    send_buffer(make_packet(8'h34, 3, 16'd0, 1, 0));
    q = make_packet(TYPE_PUBLISH, 5, 16'd1, 3, 0);
    while (q.size() > 3) void'(q.pop_back());
    send_buffer(q);
    send_buffer(make_packet(TYPE_PUBLISH, 6, 16'd1, 2, 0));
    // padded two-digit length
    send_buffer(make_packet(TYPE_PUBLISH, 4, 16'd1, 2, 2));
  endtask

  task automatic test_capacity_edges();
    drain();
    set_caps(16'd0, 16'd65535);
    send_buffer(make_packet(8'h31, 6, 16'd2, 4, 0));
    drain();
    set_caps(16'd65535, 16'd0);
    send_buffer(make_packet(TYPE_PUBLISH, 6, 16'd2, 4, 0));
    drain();
    set_caps(16'd1, 16'd1);
    send_buffer(make_packet(TYPE_PUBLISH, 6, 16'd2, 4, 0));
    drain();
    set_caps(16'd2, 16'd2);
    send_buffer(make_packet(TYPE_PUBLISH, 7, 16'd2, 5, 0));
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct);
    logic [15:0] tcaps[6];
    logic [15:0] pcaps[6];
    int unsigned sent;
    int unsigned n;
    src_idle = src_pct;
    sink_idle = sink_pct;
    tcaps = '{TOPIC_CAP_RESET, 16'd0, 16'd3, 16'd65535, 16'd2, 16'($urandom_range(1, 400))};
    pcaps = '{PAYLOAD_CAP_RESET, 16'd65535, 16'd0, 16'd1, 16'd5, 16'($urandom_range(1, 400))};
    for (int i = 0; i < 6; i++) begin
      drain();
      set_caps(tcaps[i], pcaps[i]);
      sent = 0;
      while (sent < 90) begin
        send_random_packet(n);
        sent = sent + n;
      end
    end
  endtask

  // packet reaching the last position, buffer cut short inside the topic
  task automatic test_longest_packet();
    drain();
    set_caps(16'd65535, 16'd65535);
    send_buffer(make_packet(TYPE_PUBLISH, 65531, 16'd300, 40, 0));
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= sink_idle);

  always @(posedge clk) begin
    parsed_t want;
    if (!rst && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h kind %0d done %0b status %0b",
                   out_byte, byte_kind, packet_done, status);
      end else begin
        want = parsed_q.pop_front();
        if (out_byte !== want.data || byte_kind !== want.kind ||
            packet_done !== want.done || status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte %02h kind %0d done %0b status %0b, got %02h %0d %0b %0b",
                     want.data, want.kind, want.done, want.status,
                     out_byte, byte_kind, packet_done, status);
        end
      end
    end
  end

  // cycles without any transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_TOPIC_CAPACITY;
    cfg_data = 16'h0000;
    mismatches = 0;
    quiet = 0;
    src_idle = 0;
    sink_idle = 0;
    topic_cap = TOPIC_CAP_RESET;
    payload_cap = PAYLOAD_CAP_RESET;
    clear_parse();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_capacity_edges();
    test_random_traffic(28, 69);
    test_random_traffic(69, 28);
    test_random_traffic(0, 0);
    test_longest_packet();
    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
